// ===== rtl/shc_pkg.sv =====
// Shared definitions for the slab heat conduction step block.
// Node count, operand widths of the shared multiplier and its request type.
// No dependencies.
`default_nettype none

package shc_pkg;

	// Number of slab nodes in the column (node 0 is the surface).
	localparam int NODES   = 20;
	localparam int NODE_AW = $clog2(NODES);

	// Shared multiplier: signed A times signed B, full-width product.
	localparam int MUL_AW = 42;
	localparam int MUL_BW = 25;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	typedef struct packed {
		logic                     en;
		logic signed [MUL_AW-1:0] a;
		logic signed [MUL_BW-1:0] b;
	} mul_req_t;

endpackage

`default_nettype wire

// ===== rtl/shc_mul.sv =====
// Registered signed multiplier shared by every product of a time step.
// Depends on shc_pkg for the operand widths and the request struct.
`default_nettype none

module shc_mul
	import shc_pkg::*;
(
	input  wire logic                     clk,
	input  wire mul_req_t                 req,
	output logic signed [MUL_PW-1:0]      prod_q
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= MUL_PW'(req.a) * MUL_PW'(req.b);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/slab_heat_conduction_step.sv =====
// Top level of the slab heat conduction step block.
// Holds the node memory and the step sequencer; uses shc_pkg and shc_mul.
`default_nettype none

// A column of NODES slab temperatures (Q9.7 kelvin, node 0 at the surface) is
// kept in a small on-chip memory. A start beat with req_type 0 loads one node
// and its result beat (an echo of load_temp, all flags clear) appears on the
// next cycle; busy stays low, so loads may follow each other every cycle.
// A start beat with req_type 1 advances the whole column by one explicit
// finite-difference time step. It keeps busy high until the last node is
// written back, and the result beat comes in the same cycle that busy
// falls, in which the next start beat may already be taken. The step length
// is set by the single shared multiplier, which serves the conductance, flux
// and stability products and then one product per middle node and two per
// edge node, with the node updates walking the memory one address at a time.
// Results are shown for exactly one cycle with done high; the receiver cannot
// stall them, so they must be captured when done is seen. Every node must be
// loaded before the first step. Configuration writes are accepted at any edge
// with cfg_write high but are meant for an idle block.
module slab_heat_conduction_step
	import shc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_write,
	input  wire logic               cfg_index,
	input  wire logic [23:0]        cfg_data,
	// command side
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               req_type,
	input  wire logic [4:0]         node_index,
	input  wire logic [15:0]        load_temp,
	input  wire logic [15:0]        surface_temp,
	input  wire logic [15:0]        air_temp,
	input  wire logic [15:0]        conv_coeff,
	input  wire logic signed [23:0] surface_flux,
	// result side
	output logic                    done,
	output logic [15:0]             new_surface_temp,
	output logic                    unstable_fault,
	output logic                    rate_fault,
	output logic                    low_temp_fault
);

	// Register indexes of the configuration port.
	localparam logic REG_INV_MESH = 1'b0;
	localparam logic REG_SPACING  = 1'b1;

	// Request codes.
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;  // waiting for a start beat
	localparam logic [3:0] S_G    = 4'd1;  // g = h * s
	localparam logic [3:0] S_UNS  = 4'd2;  // (1 + g) * a for the stability flag
	localparam logic [3:0] S_FLX  = 4'd3;  // flux * s
	localparam logic [3:0] S_CONV = 4'd4;  // g * (Ta - T), edge node
	localparam logic [3:0] S_BR   = 4'd5;  // bracket sum and rounding
	localparam logic [3:0] S_EMUL = 4'd6;  // bracket * 2a, edge node
	localparam logic [3:0] S_MMUL = 4'd7;  // bracket * a, middle node
	localparam logic [3:0] S_FIN  = 4'd8;  // round, saturate, write back

	localparam logic [NODE_AW-1:0] LAST    = NODE_AW'(NODES - 1);
	localparam logic [NODE_AW-1:0] LAST_M1 = NODE_AW'(NODES - 2);

	localparam logic signed [MUL_PW-1:0] UNS_LIMIT =
		{{(MUL_PW-48){1'b0}}, 1'b1, {47{1'b0}}};
	localparam logic signed [63:0] BR_HALF  = 64'sd1 <<< 22;
	localparam logic signed [MUL_PW-1:0] FIN_HALF =
		{{(MUL_PW-25){1'b0}}, 1'b1, {24{1'b0}}};

	localparam logic [15:0] LOW_LIMIT  = 16'd25600;  // 200 K
	localparam logic [16:0] RATE_LIMIT = 17'd512;    // 4 K

	// Configuration registers.
	logic [15:0] a_q;
	logic [23:0] s_q;

	// Sequencer control.
	logic [3:0]         state_q;
	logic [NODE_AW-1:0] n_q;

	// Step operands latched at the start beat.
	logic [15:0]        ta_q;
	logic [15:0]        h_q;
	logic signed [23:0] flux_q;

	// Datapath registers.
	logic [39:0]        g_q;
	logic signed [63:0] acc_q;
	logic signed [37:0] b16_q;
	logic [15:0]        m_q;     // old value of the node above
	logic [15:0]        c_q;     // old value of the node being updated
	logic [15:0]        p_q;     // old value of the node below

	// Result registers.
	logic        done_q;
	logic [15:0] res_temp_q;
	logic        res_uns_q;
	logic        res_rate_q;
	logic        res_low_q;

	// Node memory: one write and one registered read each cycle.
	logic [15:0]        node_mem [NODES];
	logic [15:0]        rd_q;
	logic               rd_en;
	logic [NODE_AW-1:0] rd_addr;
	logic               wr_en;
	logic [NODE_AW-1:0] wr_addr;
	logic [15:0]        wr_data;

	// Shared multiplier.
	mul_req_t                mul_req;
	logic signed [MUL_PW-1:0] prod_q;

	shc_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	logic accept;
	logic is_top;
	assign accept = start && (state_q == S_IDLE);
	assign is_top = (n_q == '0);

	// Differences of neighbor temperatures, exact in a few extra bits.
	logic signed [16:0] air_diff;
	logic signed [16:0] edge_diff;
	logic signed [17:0] mid_diff;
	logic [15:0]        edge_nbr;

	assign edge_nbr  = is_top ? p_q : m_q;
	assign air_diff  = $signed({1'b0, ta_q}) - $signed({1'b0, c_q});
	assign edge_diff = $signed({1'b0, edge_nbr}) - $signed({1'b0, c_q});
	assign mid_diff  = $signed({2'b00, m_q}) + $signed({2'b00, p_q})
		- $signed({1'b0, c_q, 1'b0});

	// Bracket sum at scale 2^-39, rounding constant already in the accumulator.
	logic signed [63:0] br_sum;
	assign br_sum = 64'(prod_q) + acc_q;

	// Final node value: round half up to Q9.7 and saturate.
	logic signed [MUL_PW-1:0] fin_sum;
	logic signed [MUL_PW-1:0] fin_r;
	logic [15:0]              fin_val;
	logic signed [16:0]       fin_delta;

	assign fin_sum = prod_q + ($signed({{(MUL_PW-16){1'b0}}, c_q}) <<< 25) + FIN_HALF;
	assign fin_r   = fin_sum >>> 25;

	always_comb begin
		if (fin_r < 0) begin
			fin_val = '0;
		end else if (fin_r > $signed(MUL_PW'(65535))) begin
			fin_val = 16'hFFFF;
		end else begin
			fin_val = fin_r[15:0];
		end
	end

	// At the top node c_q still holds the surface temperature of the step.
	assign fin_delta = $signed({1'b0, fin_val}) - $signed({1'b0, c_q});

	logic [16:0] fin_abs;
	assign fin_abs = fin_delta[16] ? 17'(-fin_delta) : 17'(fin_delta);

	// Multiplier operand selection.
	always_comb begin
		mul_req = '{en: 1'b0, a: '0, b: '0};
		unique case (state_q)
			S_G: begin
				mul_req.en = 1'b1;
				mul_req.a  = $signed({{(MUL_AW-16){1'b0}}, h_q});
				mul_req.b  = $signed({{(MUL_BW-24){1'b0}}, s_q});
			end
			S_UNS: begin
				// 1 + g at scale 2^-32 is 2^32 + g.
				mul_req.en = 1'b1;
				mul_req.a  = $signed({{(MUL_AW-41){1'b0}}, 41'(prod_q[39:0]) + (41'd1 << 32)});
				mul_req.b  = $signed({{(MUL_BW-16){1'b0}}, a_q});
			end
			S_FLX: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_AW'(flux_q);
				mul_req.b  = $signed({{(MUL_BW-24){1'b0}}, s_q});
			end
			S_CONV: begin
				mul_req.en = 1'b1;
				mul_req.a  = $signed({{(MUL_AW-40){1'b0}}, g_q});
				mul_req.b  = MUL_BW'(air_diff);
			end
			S_EMUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_AW'(b16_q);
				mul_req.b  = $signed({{(MUL_BW-17){1'b0}}, a_q, 1'b0});
			end
			S_MMUL: begin
				// Middle bracket rounded to 2^-16 is exactly the difference times 2^9.
				mul_req.en = 1'b1;
				mul_req.a  = MUL_AW'(mid_diff) <<< 9;
				mul_req.b  = $signed({{(MUL_BW-16){1'b0}}, a_q});
			end
			default: begin
				mul_req = '{en: 1'b0, a: '0, b: '0};
			end
		endcase
	end

	// Memory port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = fin_val;
		unique case (state_q)
			S_IDLE: begin
				if (start && req_type == REQ_STEP) begin
					rd_en   = 1'b1;
					rd_addr = NODE_AW'(1);
				end
				if (start && req_type == REQ_LOAD && int'(node_index) < NODES) begin
					wr_en   = 1'b1;
					wr_addr = NODE_AW'(node_index);
					wr_data = load_temp;
				end
			end
			S_G: begin
				rd_en   = 1'b1;
				rd_addr = NODE_AW'(2);
			end
			S_MMUL: begin
				// Fetch the node below the next one, where there is one.
				if (int'(n_q) + 2 < NODES) begin
					rd_en   = 1'b1;
					rd_addr = n_q + NODE_AW'(2);
				end
			end
			S_FIN: begin
				wr_en   = 1'b1;
				wr_addr = n_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= node_mem[rd_addr];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 16'd16384;
			s_q <= 24'd117440;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_INV_MESH: a_q <= cfg_data[15:0];
				REG_SPACING:  s_q <= cfg_data;
				default:      a_q <= a_q;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						n_q <= '0;
						if (req_type == REQ_STEP) begin
							state_q <= S_G;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_G:    state_q <= S_UNS;
				S_UNS:  state_q <= S_FLX;
				S_FLX:  state_q <= S_CONV;
				S_CONV: state_q <= S_BR;
				S_BR:   state_q <= S_EMUL;
				S_EMUL: state_q <= S_FIN;
				S_MMUL: state_q <= S_FIN;
				S_FIN: begin
					if (n_q == LAST) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						n_q     <= n_q + NODE_AW'(1);
						state_q <= (n_q == LAST_M1) ? S_CONV : S_MMUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath and result registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept && req_type == REQ_STEP) begin
					ta_q   <= air_temp;
					h_q    <= conv_coeff;
					flux_q <= surface_flux;
					c_q    <= surface_temp;
				end
				if (accept && req_type == REQ_LOAD) begin
					res_temp_q <= load_temp;
					res_uns_q  <= 1'b0;
					res_rate_q <= 1'b0;
					res_low_q  <= 1'b0;
				end
			end
			S_G: begin
				p_q <= rd_q;
			end
			S_UNS: begin
				g_q <= prod_q[39:0];
			end
			S_FLX: begin
				res_uns_q <= (prod_q > UNS_LIMIT);
			end
			S_CONV: begin
				// Flux term (top only), neighbor term and the rounding half.
				acc_q <= (is_top ? (64'(prod_q) <<< 11) : 64'sd0)
					+ (64'(edge_diff) <<< 32) + BR_HALF;
			end
			S_BR: begin
				b16_q <= 38'(br_sum >>> 23);
			end
			S_FIN: begin
				if (is_top) begin
					res_temp_q <= fin_val;
					res_rate_q <= (fin_abs > RATE_LIMIT);
					res_low_q  <= (fin_val < LOW_LIMIT);
				end
				m_q <= c_q;
				c_q <= p_q;
				p_q <= rd_q;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign new_surface_temp = res_temp_q;
	assign unstable_fault   = res_uns_q;
	assign rate_fault       = res_rate_q;
	assign low_temp_fault   = res_low_q;

	// The last node update ends the step with exactly one result beat.
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && n_q == LAST) |=> (done_q && state_q == S_IDLE))
		else $error("step finished without a result beat");

	// The node being written back is never the one being fetched.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("node memory read and write to the same address");

	// Middle-node products only occur for middle nodes.
	a_mid_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MMUL) |-> (n_q != '0 && n_q != LAST))
		else $error("middle update on an edge node");

	// No result beat appears while a step is still running.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE || $past(state_q) == S_IDLE))
		else $error("result beat during a step");

endmodule

`default_nettype wire
